>>> hw/rtl/ihrp_pkg.sv
// Shared types and constants of the Intel HEX record patcher.
`timescale 1ns / 1ps
`default_nettype none

package ihrp_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_OFFSET   = 2'd0,
        CFG_KEY_INTERVAL = 2'd1,
        CFG_KEY_LENGTH   = 2'd2
    } t_cfg_idx;

    // Register reset values
    localparam logic [15:0] KEY_OFFSET_RST   = 16'd472;
    localparam logic [8:0]  KEY_INTERVAL_RST = 9'd2;
    localparam logic [5:0]  KEY_LENGTH_RST   = 6'd20;

    // Characters with a fixed meaning in a record line
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Controller to datapath commands
    typedef struct packed {
        logic       key_wr;     // write key byte of the item being transferred
        logic       capture;    // latch line character of the item being transferred
        logic       div_start;  // load divider with current address offset
        logic       div_step;   // one restoring division step
        logic       exec;       // commit one character step, load output list
        logic [1:0] out_idx;    // output list entry on the result port
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic       div_needed; // key position must be recomputed before the step
        logic       div_done;   // last division step in this cycle
        logic [1:0] n_next;     // length of the list that exec loads
        logic [1:0] n;          // length of the loaded output list
    } t_status;

endpackage

`default_nettype wire

>>> hw/rtl/ihrp_dpath.sv
// Datapath of the Intel HEX record patcher: parser state, key table, divider, output list.
`timescale 1ns / 1ps
`default_nettype none

module ihrp_dpath #(
    parameter int KEY_DEPTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ihrp_pkg::t_cmd                 i_cmd,
    output ihrp_pkg::t_status                   o_status,
    input  wire logic                           i_func,
    input  wire logic [4:0]                     i_key_slot,
    input  wire logic [7:0]                     i_key_value,
    input  wire logic [7:0]                     i_line_char,
    input  wire logic                           i_line_done,
    input  wire logic                           i_cfg_we,
    input  wire logic [ihrp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ihrp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [7:0]                          o_out_char,
    output logic                                o_run_last,
    output logic                                o_record_bad
);

    localparam int          AW      = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam logic [8:0]  DEPTH9  = 9'(KEY_DEPTH);
    localparam logic [16:0] DEPTH17 = 17'(KEY_DEPTH);

    typedef enum logic [3:0] {
        PH_WAIT, PH_COUNT, PH_ADHI, PH_ADLO, PH_TYPE, PH_DATA, PH_CSUM, PH_TAIL, PH_BAD
    } t_phase;

    function automatic logic [7:0] f_hex(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) r = 8'h30 + {4'h0, v};
        else           r = 8'h37 + {4'h0, v};
        return r;
    endfunction

    // {valid, value} of one hex digit, either case
    function automatic logic [4:0] f_nib(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        return r;
    endfunction

    // Configuration
    logic [15:0] r_off;
    logic [8:0]  r_int;
    logic [5:0]  r_len;

    // Line parser state
    t_phase      r_phase, n_phase;
    logic [3:0]  r_hn, n_hn;
    logic        r_hv, n_hv;
    logic        r_pos, n_pos;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_left, n_left;
    logic        r_err, n_err;

    // Captured character
    logic [7:0]  r_c;
    logic        r_done;

    // Key position: address above offset, remainder and quotient by interval
    logic        r_ge, n_ge;
    logic [8:0]  r_rem, n_rem;
    logic [15:0] r_idx, n_idx;
    logic [15:0] r_dvd, n_dvd;
    logic [3:0]  r_dcnt;
    logic        r_need_div;

    // Key table
    logic [7:0]  mem [KEY_DEPTH];
    logic [7:0]  r_kb;
    logic        r_kb_in;

    // Output list
    logic [7:0]  r_ech [3];
    logic [7:0]  n_ech [3];
    logic [1:0]  r_n, n_n;
    logic        r_lf_bad, n_lf_bad;

    logic        addr_step;
    logic        adlo_done;
    logic [15:0] inc_addr;

    logic [8:0]  slot9;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign slot9   = {4'h0, i_key_slot};
    assign wr_addr = slot9[AW-1:0];
    assign rd_addr = r_idx[AW-1:0];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= ihrp_pkg::KEY_OFFSET_RST;
            r_int <= ihrp_pkg::KEY_INTERVAL_RST;
            r_len <= ihrp_pkg::KEY_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ihrp_pkg::CFG_KEY_OFFSET:   r_off <= i_cfg_data;
                ihrp_pkg::CFG_KEY_INTERVAL: r_int <= i_cfg_data[8:0];
                ihrp_pkg::CFG_KEY_LENGTH:   r_len <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Key table: one write port, registered read at the current key index
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_wr && !i_func && slot9 < DEPTH9) begin
            mem[wr_addr] <= i_key_value;
        end
        r_kb    <= mem[rd_addr];
        r_kb_in <= {1'b0, r_idx} < DEPTH17;
    end

    // Character step
    logic [7:0] kb, pv, cs, e_char;
    logic [4:0] nb;
    logic       hit, e_have;

    always_comb begin
        kb  = r_kb_in ? r_kb : 8'h00;
        hit = (r_kind == 8'h00) && (r_int != 9'd0) && r_ge && (r_rem == 9'd0) &&
              (r_idx < {10'd0, r_len});
        nb  = f_nib(r_c);
        if (!r_hv)      pv = 8'h00;
        else if (!nb[4]) pv = {4'h0, r_hn};
        else            pv = {r_hn, nb[3:0]};
        cs  = 8'h00 - r_sum;

        n_phase = r_phase; n_hn = r_hn; n_hv = r_hv; n_pos = r_pos;
        n_count = r_count; n_addr = r_addr; n_kind = r_kind; n_sum = r_sum;
        n_left = r_left; n_err = r_err;
        e_have = 1'b0; e_char = r_c;
        addr_step = 1'b0;
        adlo_done = 1'b0;
        inc_addr  = r_addr + 16'd1;

        case (r_phase)
            PH_WAIT: begin
                e_have = 1'b1;
                if (r_c == ihrp_pkg::CH_COLON) begin
                    n_hn = 4'h0; n_hv = 1'b0; n_pos = 1'b0; n_count = 8'h00;
                    n_addr = 16'h0000; n_kind = 8'h00; n_sum = 8'h00;
                    n_left = 8'h00; n_err = 1'b0;
                    n_phase = PH_COUNT;
                end else begin
                    n_phase = PH_BAD;
                    n_err   = 1'b1;
                end
            end
            PH_COUNT, PH_ADHI, PH_ADLO, PH_TYPE: begin
                e_have = 1'b1;
                if (!r_pos) begin
                    n_hv = nb[4]; n_hn = nb[3:0]; n_pos = 1'b1;
                end else begin
                    n_pos = 1'b0;
                    n_sum = r_sum + pv;
                    unique case (r_phase)
                        PH_COUNT: begin
                            n_count = pv; n_phase = PH_ADHI;
                        end
                        PH_ADHI: begin
                            n_addr = {pv, 8'h00}; n_phase = PH_ADLO;
                        end
                        PH_ADLO: begin
                            n_addr = {r_addr[15:8], pv}; n_phase = PH_TYPE;
                            adlo_done = 1'b1;
                        end
                        default: begin
                            n_kind  = pv;
                            n_left  = r_count;
                            n_phase = (r_count != 8'h00) ? PH_DATA : PH_CSUM;
                        end
                    endcase
                end
            end
            PH_DATA: begin
                e_have = 1'b1;
                if (!r_pos) begin
                    e_char = (hit && !r_done) ? f_hex(kb[7:4]) : r_c;
                    n_hv = nb[4]; n_hn = nb[3:0]; n_pos = 1'b1;
                end else begin
                    n_pos = 1'b0;
                    if (hit) begin
                        e_char = (r_done && r_left != 8'd1) ? r_c : f_hex(kb[3:0]);
                        n_sum  = r_sum + kb;
                    end else begin
                        n_sum  = r_sum + pv;
                    end
                    n_addr    = inc_addr;
                    addr_step = 1'b1;
                    n_left    = r_left - 8'd1;
                    if (r_left == 8'd1) n_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                e_have = 1'b1;
                if (!r_pos) begin
                    e_char = r_done ? r_c : f_hex(cs[7:4]);
                    n_pos  = 1'b1;
                end else begin
                    e_char  = f_hex(cs[3:0]);
                    n_pos   = 1'b0;
                    n_phase = PH_TAIL;
                end
            end
            PH_TAIL: ;
            default: begin
                // Bad record, and any unused phase code: pass through, flagged
                e_have  = 1'b1;
                n_phase = PH_BAD;
                n_err   = 1'b1;
            end
        endcase

        // Line end: CR LF, flag the LF, start over
        n_lf_bad = r_done && (n_err || (n_phase != PH_TAIL));
        if (r_done) begin
            n_phase = PH_WAIT;
            n_hn = 4'h0; n_hv = 1'b0; n_pos = 1'b0; n_count = 8'h00;
            n_addr = 16'h0000; n_kind = 8'h00; n_sum = 8'h00;
            n_left = 8'h00; n_err = 1'b0;
        end

        // Output list
        if (e_have) begin
            n_ech[0] = e_char;
            n_ech[1] = ihrp_pkg::CH_CR;
            n_ech[2] = ihrp_pkg::CH_LF;
            n_n      = r_done ? 2'd3 : 2'd1;
        end else begin
            n_ech[0] = ihrp_pkg::CH_CR;
            n_ech[1] = ihrp_pkg::CH_LF;
            n_ech[2] = ihrp_pkg::CH_LF;
            n_n      = r_done ? 2'd2 : 2'd0;
        end
    end

    // Key position: division at the first data character of a record or after a
    // register write, then tracked as the address advances
    logic [9:0] t_try, t_sub;
    logic [9:0] rp1;
    logic       q_bit;

    always_comb begin
        n_ge  = r_ge;
        n_rem = r_rem;
        n_idx = r_idx;
        n_dvd = r_dvd;
        t_try = {r_rem, r_dvd[15]};
        t_sub = t_try - {1'b0, r_int};
        q_bit = t_try >= {1'b0, r_int};
        rp1   = {1'b0, r_rem} + 10'd1;
        if (i_cmd.div_start) begin
            n_ge  = r_addr >= r_off;
            n_dvd = r_addr - r_off;
            n_rem = 9'd0;
            n_idx = 16'd0;
        end else if (i_cmd.div_step) begin
            n_rem = q_bit ? t_sub[8:0] : t_try[8:0];
            n_idx = {r_idx[14:0], q_bit};
            n_dvd = {r_dvd[14:0], 1'b0};
        end else if (i_cmd.exec && addr_step) begin
            if (inc_addr == r_off) begin
                n_ge = 1'b1; n_rem = 9'd0; n_idx = 16'd0;
            end else if (r_addr == 16'hFFFF) begin
                n_ge = 1'b0;
            end else if (r_ge) begin
                if (rp1 == {1'b0, r_int}) begin
                    n_rem = 9'd0;
                    n_idx = r_idx + 16'd1;
                end else begin
                    n_rem = rp1[8:0];
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT; r_hn <= 4'h0; r_hv <= 1'b0; r_pos <= 1'b0;
            r_count <= 8'h00; r_addr <= 16'h0000; r_kind <= 8'h00; r_sum <= 8'h00;
            r_left <= 8'h00; r_err <= 1'b0;
            r_ge <= 1'b0; r_rem <= 9'd0; r_idx <= 16'd0; r_dcnt <= 4'd0;
            r_need_div <= 1'b1;
            r_n <= 2'd0; r_lf_bad <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_phase <= n_phase; r_hn <= n_hn; r_hv <= n_hv; r_pos <= n_pos;
                r_count <= n_count; r_addr <= n_addr; r_kind <= n_kind; r_sum <= n_sum;
                r_left <= n_left; r_err <= n_err;
                r_n <= n_n; r_lf_bad <= n_lf_bad;
            end
            r_ge  <= n_ge;
            r_rem <= n_rem;
            r_idx <= n_idx;
            if (i_cmd.div_start)     r_dcnt <= 4'd0;
            else if (i_cmd.div_step) r_dcnt <= r_dcnt + 4'd1;
            if (i_cfg_we || (i_cmd.exec && adlo_done)) r_need_div <= 1'b1;
            else if (o_status.div_done)                r_need_div <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_c    <= i_line_char;
            r_done <= i_line_done;
        end
        r_dvd <= n_dvd;
        if (i_cmd.exec) begin
            r_ech[0] <= n_ech[0];
            r_ech[1] <= n_ech[1];
            r_ech[2] <= n_ech[2];
        end
    end

    // Status
    always_comb begin
        o_status.div_needed = r_need_div && (r_phase == PH_DATA);
        o_status.div_done   = i_cmd.div_step && (r_dcnt == 4'd15);
        o_status.n_next     = n_n;
        o_status.n          = r_n;
    end

    // Result port
    always_comb begin
        unique case (i_cmd.out_idx)
            2'd0:    o_out_char = r_ech[0];
            2'd1:    o_out_char = r_ech[1];
            default: o_out_char = r_ech[2];
        endcase
        o_run_last   = i_cmd.out_idx == (r_n - 2'd1);
        o_record_bad = r_lf_bad && o_run_last;
    end

endmodule

`default_nettype wire

>>> hw/rtl/ihrp_ctrl.sv
// Controller state machine of the Intel HEX record patcher.
`timescale 1ns / 1ps
`default_nettype none

module ihrp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_func,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ihrp_pkg::t_cmd          o_cmd,
    input  wire ihrp_pkg::t_status  i_status
);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_LOOK, S_EXEC, S_EMIT} t_state;

    t_state     r_state;
    logic       r_out_valid;
    logic [1:0] r_oidx;
    logic       in_xfer, out_xfer;

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign in_xfer     = i_in_valid && (r_state == S_IDLE);
    assign out_xfer    = r_out_valid && !i_out_stall;

    // Commands
    always_comb begin
        o_cmd.key_wr    = in_xfer && !i_func;
        o_cmd.capture   = in_xfer && i_func;
        o_cmd.div_start = in_xfer && i_func && i_status.div_needed;
        o_cmd.div_step  = r_state == S_DIV;
        o_cmd.exec      = r_state == S_EXEC;
        o_cmd.out_idx   = r_oidx;
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_oidx      <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_func) begin
                        r_state <= i_status.div_needed ? S_DIV : S_LOOK;
                    end
                end
                S_DIV: begin
                    if (i_status.div_done) r_state <= S_LOOK;
                end
                S_LOOK: r_state <= S_EXEC;
                S_EXEC: begin
                    r_oidx <= 2'd0;
                    if (i_status.n_next != 2'd0) begin
                        r_state     <= S_EMIT;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_xfer) begin
                        if (r_oidx == i_status.n - 2'd1) begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 2'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_valid_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_out_valid == (r_state == S_EMIT)))
        else $error("result valid outside emit state");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_oidx < i_status.n))
        else $error("output index beyond list");

    a_exec_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && i_status.n_next != 2'd0) |=> o_out_valid)
        else $error("results not offered after step");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_status.div_done) |=> (r_state == S_LOOK))
        else $error("division did not hand over to lookup");

endmodule

`default_nettype wire

>>> hw/rtl/intel_hex_record_patcher_top.sv
// Top level of the Intel HEX record patcher.
`timescale 1ns / 1ps
`default_nettype none

// Rewrites Intel HEX record lines one character per input transfer and places
// key bytes into data records at the key base address plus whole multiples of
// the key step, for key indexes below the key length, recomputing the checksum
// and closing every line with CR LF. A key load (func 0) is written straight
// into the key table when taken. A line character runs through a lookup state
// for the registered key table read and an execute state, then offers its
// result characters (0 to 3) one by one, held while the result side stalls;
// no new input is taken until the last is accepted. The first data character
// of a record, and the next data character after a register write, also runs
// a 16-step restoring divider that finds the key slot for the current address
// before the lookup; later bytes track the slot incrementally.
module intel_hex_record_patcher_top #(
    parameter int KEY_DEPTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_func,
    input  wire logic [4:0]                      i_key_slot,
    input  wire logic [7:0]                      i_key_value,
    input  wire logic [7:0]                      i_line_char,
    input  wire logic                            i_line_done,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [7:0]                           o_out_char,
    output logic                                 o_run_last,
    output logic                                 o_record_bad,
    input  wire logic                            i_cfg_we,
    input  wire logic [ihrp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ihrp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ihrp_pkg::t_cmd    cmd;
    ihrp_pkg::t_status status;

    // Sequencer
    ihrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // Parser, key table and result list
    ihrp_dpath #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_func       (i_func),
        .i_key_slot   (i_key_slot),
        .i_key_value  (i_key_value),
        .i_line_char  (i_line_char),
        .i_line_done  (i_line_done),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_char   (o_out_char),
        .o_run_last   (o_run_last),
        .o_record_bad (o_record_bad)
    );

endmodule

`default_nettype wire
